[sv/lidar_edge_waypoint_steer_macros.svh]
// ----------------------------------------------------------------------------
// lidar_edge_waypoint_steer_macros
// Assertion macros shared by the steering block.
// ----------------------------------------------------------------------------
`ifndef LIDAR_EDGE_WAYPOINT_STEER_MACROS_SVH
`define LIDAR_EDGE_WAYPOINT_STEER_MACROS_SVH
// implication checked every clock, quiet during reset
`define LEWS_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lews check failed");
// next-cycle implication
`define LEWS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lews check failed");
`endif

[sv/lews_pkg.sv]
// ----------------------------------------------------------------------------
// lews_pkg
// Shared constants and types for the lidar edge waypoint steering block.
// ----------------------------------------------------------------------------
package lews_pkg;
  localparam int ScanPoints  = 256;
  localparam int CordicSteps = 16;
  localparam int StepW       = 5;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [16:0] PiQ13 = 17'sd25736;
  localparam logic signed [33:0] InvGainQ30 = 34'sd652032874;
  localparam logic [31:0] DegToQ16 = 32'd74961321;

  localparam logic [2:0] RegDrop  = 3'd0;
  localparam logic [2:0] RegArr   = 3'd1;
  localparam logic [2:0] RegSide  = 3'd2;
  localparam logic [2:0] RegFirst = 3'd3;
  localparam logic [2:0] RegLast  = 3'd4;

  function automatic logic signed [19:0] atan_q16(input logic [StepW-1:0] k);
    case (k)
      5'd0: atan_q16 = 20'sd51472;  5'd1: atan_q16 = 20'sd30385;
      5'd2: atan_q16 = 20'sd16055;  5'd3: atan_q16 = 20'sd8150;
      5'd4: atan_q16 = 20'sd4091;   5'd5: atan_q16 = 20'sd2047;
      5'd6: atan_q16 = 20'sd1024;   5'd7: atan_q16 = 20'sd512;
      5'd8: atan_q16 = 20'sd256;    5'd9: atan_q16 = 20'sd128;
      5'd10: atan_q16 = 20'sd64;    5'd11: atan_q16 = 20'sd32;
      5'd12: atan_q16 = 20'sd16;    5'd13: atan_q16 = 20'sd8;
      5'd14: atan_q16 = 20'sd4;     5'd15: atan_q16 = 20'sd2;
      5'd16: atan_q16 = 20'sd1;
      default: atan_q16 = 20'sd0;
    endcase
  endfunction

  typedef struct packed {
    logic [15:0]        drop_threshold;
    logic [15:0]        arrive_radius;
    logic signed [19:0] side_offset;
    logic [7:0]         window_first;
    logic [7:0]         window_last;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  sample_index;
    logic [15:0] depth;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] yaw;
    logic signed [19:0] target_x;
    logic signed [19:0] target_y;
  } in_t;

  typedef struct packed {
    logic        forward_drive;
    logic signed [15:0] turn_drive;
    logic        edge_found;
    logic [7:0]  edge_index;
  } out_t;

  // CORDIC control: start and mode (1 = vectoring); done comes back on its own port
  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;
endpackage

[sv/lews_stream_if.sv]
// ----------------------------------------------------------------------------
// lews_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lews_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/lews_cordic.sv]
// ----------------------------------------------------------------------------
// lews_cordic
// Shared CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module lews_cordic
  import lews_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cordic_ctl_t        ctl,
  input  logic signed [33:0] x_in,
  input  logic signed [33:0] y_in,
  input  logic signed [19:0] z_in,
  output logic signed [33:0] x_out,
  output logic signed [33:0] y_out,
  output logic signed [19:0] z_out,
  output logic               done
);
  logic signed [33:0] x, y;
  logic signed [19:0] z;
  logic [StepW-1:0]   k;
  logic               busy, vec;
  logic signed [33:0] xs, ys;
  logic               dir;

  assign xs  = x >>> k;
  assign ys  = y >>> k;
  assign dir = vec ? ~y[33] : ~z[19];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
      vec  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        vec  <= ctl.vectoring;
        k    <= '0;
        x    <= x_in;
        y    <= y_in;
        z    <= z_in;
      end else if (busy) begin
        if (dir == vec) begin
          // vectoring with y >= 0, or rotation with z < 0
          x <= x + ys; y <= y - xs; z <= z + atan_q16(k);
        end else begin
          x <= x - ys; y <= y + xs; z <= z - atan_q16(k);
        end
        if (k == StepW'(CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        k <= k + 1'b1;
      end
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = z;
endmodule

[sv/lews_regs.sv]
// ----------------------------------------------------------------------------
// lews_regs
// APB register file for the steering block settings.
// ----------------------------------------------------------------------------
module lews_regs
  import lews_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  logic [2:0] idx;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drop_threshold <= 16'd1536;
      cfg.arrive_radius  <= 16'd102;
      cfg.side_offset    <= 20'sd2048;
      cfg.window_first   <= 8'd60;
      cfg.window_last    <= 8'd110;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegDrop:  cfg.drop_threshold <= pwdata[15:0];
        RegArr:   cfg.arrive_radius  <= pwdata[15:0];
        RegSide:  cfg.side_offset    <= pwdata[19:0];
        RegFirst: cfg.window_first   <= pwdata[7:0];
        RegLast:  cfg.window_last    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDrop:  prdata = {16'd0, cfg.drop_threshold};
      RegArr:   prdata = {16'd0, cfg.arrive_radius};
      RegSide:  prdata = {{12{cfg.side_offset[19]}}, cfg.side_offset};
      RegFirst: prdata = {24'd0, cfg.window_first};
      RegLast:  prdata = {24'd0, cfg.window_last};
      default:  prdata = 32'd0;
    endcase
  end
endmodule

[sv/lidar_edge_waypoint_steer.sv]
// ----------------------------------------------------------------------------
// lidar_edge_waypoint_steer
// Tangent-bug steering: lidar edge tracking plus CORDIC waypoint steering.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : input beats. mode 0 = lidar sample, mode 1 = steer request.
//   out_ch : one result beat per steer request, none for samples.
//   APB    : five settings at byte addresses 0,4,8,12,16; write while idle.
// Request flow:
//   A lidar sample is absorbed while idle; the next beat is taken at once.
//   A steer request without an edge runs one vectoring CORDIC pass
//   (16 steps) in S_VEC and S_WAIT, then the squares in S_SQX and S_SQY;
//   S_OUT raises the result beat and returns to idle for the next beat.
//   With an edge, a rotation pass for sin/cos comes first, then S_OFS.
//   A zero aim vector skips the vectoring pass and goes on to S_SQX.
//   The distance test is two 21x21 squares done on separate cycles.
// Reset: edge record and previous sample clear, registers take defaults.
// Stall: the result sits in an output register; the block takes a new beat
//   while it waits, but a further steer request holds until it is taken.
// ----------------------------------------------------------------------------
module lidar_edge_waypoint_steer
  import lews_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lews_stream_if.sink   in_ch,
  lews_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "lidar_edge_waypoint_steer_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_ROT   = 8'b00000010,
    S_OFS   = 8'b00000100,
    S_VEC   = 8'b00001000,
    S_WAIT  = 8'b00010000,
    S_SQX   = 8'b00100000,
    S_SQY   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  cfg_t   cfg;
  in_t    req;
  state_t state;

  logic [15:0] prev_depth, edge_depth;
  logic [7:0]  prev_index, edge_angle_index;
  logic        prev_valid, edge_valid;

  logic signed [20:0] dx, dy;
  logic signed [41:0] acc;
  logic signed [19:0] th;
  logic [1:0]         quad;
  logic               started;

  cordic_ctl_t        cctl;
  logic signed [33:0] cx_in, cy_in, cx, cy;
  logic signed [19:0] cz_in, cz;
  logic               cdone;

  out_t out_q;
  logic out_valid;

  lews_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  lews_cordic u_cordic (
    .clk, .rst, .ctl(cctl), .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
    .x_out(cx), .y_out(cy), .z_out(cz), .done(cdone)
  );

  // steer requests wait for a free output register
  assign in_ch.ready = (state == S_IDLE) && (!out_valid || out_ch.ready || !in_ch.data.mode);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

  logic        acc_in;
  logic [7:0]  s_idx;
  logic [15:0] s_d;
  logic        hit;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign s_idx  = in_ch.data.sample_index;
  assign s_d    = in_ch.data.depth;
  assign hit = prev_valid && s_idx != 8'd0 && (prev_index + 8'd1 == s_idx) &&
               (prev_index >= cfg.window_first) && (s_idx <= cfg.window_last) &&
               ({1'b0, prev_depth} > {1'b0, s_d} &&
                (prev_depth - s_d) > cfg.drop_threshold);

  // angle fold: edge index split into quadrant and remainder in degrees
  logic [7:0]  rem;
  logic [1:0]  q_next;
  always_comb begin
    if (edge_angle_index >= 8'd180) begin
      q_next = 2'd2; rem = edge_angle_index - 8'd180;
    end else if (edge_angle_index >= 8'd90) begin
      q_next = 2'd1; rem = edge_angle_index - 8'd90;
    end else begin
      q_next = 2'd0; rem = edge_angle_index;
    end
  end
  logic [39:0] rem_prod;
  assign rem_prod = rem * DegToQ16 + 40'd32768;

  // sin/cos picked from CORDIC result by quadrant
  logic signed [33:0] sn, cs;
  always_comb begin
    case (quad)
      2'd0:    begin sn = cy;  cs = cx;  end
      2'd1:    begin sn = cx;  cs = -cy; end
      default: begin sn = -cy; cs = -cx; end
    endcase
  end

  // vector start: left half-plane turned by pi
  logic signed [33:0] vx, vy;
  logic signed [19:0] vz;
  always_comb begin
    vx = 34'(dx) <<< 8;
    vy = 34'(dy) <<< 8;
    vz = '0;
    if (dx < 0) begin
      vx = -vx; vy = -vy;
      vz = (dy >= 0) ? PiQ16 : -PiQ16;
    end
  end

  // shared multiplier: depth times sin/cos, or dx^2 / dy^2
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] mul_p;
  always_comb begin
    case (state)
      S_ROT:   begin mul_a = sn; mul_b = 21'(signed'({1'b0, edge_depth})); end
      S_OFS:   begin mul_a = cs; mul_b = 21'(signed'({1'b0, edge_depth})); end
      S_SQX:   begin mul_a = 34'(dx); mul_b = dx; end
      default: begin mul_a = 34'(dy); mul_b = dy; end
    endcase
  end
  assign mul_p = mul_a * mul_b + 55'sd536870912;

  logic signed [20:0] th13, err0, err;
  assign th13 = 21'((th + 20'sd4) >>> 3);
  assign err0 = th13 - 21'(req.yaw);
  always_comb begin
    err = err0;
    if (err0 > 21'(PiQ13)) err = err0 - 21'(2 * PiQ13);
    if (err  < -21'(PiQ13)) err = err + 21'(2 * PiQ13);
  end
  logic [42:0] sum2;
  logic [31:0] r2;
  assign sum2 = 43'(acc) + 43'(unsigned'(mul_p - 55'sd536870912));
  assign r2   = cfg.arrive_radius * cfg.arrive_radius;

  // zero aim vector never starts the vectoring pass
  always_comb begin
    cctl.start = 1'b0; cctl.vectoring = 1'b0;
    cx_in = vx; cy_in = vy; cz_in = vz;
    if (state == S_ROT && !started) begin
      cctl.start = 1'b1;
      cx_in = InvGainQ30; cy_in = '0; cz_in = 20'(rem_prod[39:16]);
    end else if (state == S_VEC && !started && !(dx == 0 && dy == 0)) begin
      cctl.start = 1'b1; cctl.vectoring = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; started <= 1'b0; out_valid <= 1'b0;
      prev_depth <= '0; prev_index <= '0; prev_valid <= 1'b0;
      edge_valid <= 1'b0; edge_angle_index <= '0; edge_depth <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (acc_in) begin
          req <= in_ch.data;
          if (in_ch.data.mode) begin
            started <= 1'b0;
            if (edge_valid) begin
              state <= S_ROT; quad <= q_next;
            end else begin
              dx <= 21'(in_ch.data.target_x) - 21'(in_ch.data.pos_x);
              dy <= 21'(in_ch.data.target_y) - 21'(in_ch.data.pos_y);
              state <= S_VEC;
            end
          end else begin
            if (s_idx == 8'd0) edge_valid <= 1'b0;
            if (hit) begin
              edge_valid <= 1'b1; edge_angle_index <= prev_index;
              edge_depth <= prev_depth;
            end
            prev_depth <= s_d; prev_index <= s_idx; prev_valid <= 1'b1;
          end
        end
        S_ROT: begin
          started <= 1'b1;
          if (cdone) begin
            dx <= 21'(mul_p >>> 30); state <= S_OFS;
          end
        end
        S_OFS: begin
          dy <= 21'(mul_p >>> 30) + 21'(cfg.side_offset);
          started <= 1'b0; state <= S_VEC;
        end
        S_VEC: begin
          if (dx == 0 && dy == 0) begin
            th <= '0; state <= S_SQX;
          end else begin
            started <= 1'b1; state <= S_WAIT;
          end
        end
        S_WAIT: if (cdone) begin
          th <= cz; state <= S_SQX;
        end
        S_SQX: begin
          acc <= 42'(mul_p - 55'sd536870912); state <= S_SQY;
        end
        S_SQY: begin
          out_q.forward_drive <= sum2 > 43'(r2);
          out_q.turn_drive    <= (sum2 > 43'(r2)) ? 16'(err) : 16'sd0;
          out_q.edge_found    <= edge_valid;
          out_q.edge_index    <= edge_valid ? edge_angle_index : 8'd0;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LEWS_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !in_ch.ready)
  `LEWS_ASSERT_IMP(a_done_in_wait, cdone, state == S_WAIT || state == S_ROT)
  `LEWS_ASSERT_NEXT(a_out_raise, state == S_OUT, out_valid)
endmodule
